@@ hw/rtl/mcmn_pkg.sv @@
// Shared types, constants and codes for the column mean / max-abs normaliser.
// Used by every module of the block; it depends on nothing else.
package mcmn_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 128;

  localparam int OPC_W      = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int STAT_W     = 2;
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = 6;

  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_NORM  = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;
  localparam logic [OPC_W-1:0] OP_RSVD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FLAT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_SUM_RD, S_SUM_ACC, S_MEAN_DIV, S_MAX_RD, S_MAX_ACC,
    S_Q_RD, S_Q_LD, S_Q_DIV, S_Q_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [ROWS_CFG_W-1:0] rows;
    logic [COLS_CFG_W-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] data;
    logic [STAT_W-1:0]          status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/column_mean_maxabs_normalizer.sv @@
// Write: one transaction per cycle while the output is not held, result in the output register next cycle.
// Read: the sample passes the registered read port of the store and then the output register.
// Normalise: per column a sum pass, a mean divide, a max pass and, for each
// row in use, a scale divide and write-back.
// Synchronous active-low reset returns control and configuration to defaults;
// the store is not cleared and holds undefined data until written.
module column_mean_maxabs_normalizer #(
  parameter int MAX_ROWS = mcmn_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcmn_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row_index [5:0], col_index [12:6], sample_value [28:13], zeros above
  input  logic [mcmn_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode [1:0]
  input  logic [mcmn_pkg::OPC_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data_out [15:0]
  output logic [mcmn_pkg::OUT_DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [mcmn_pkg::STAT_W-1:0]     out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcmn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcmn_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t     cfg_r, cfg_nxt;
  result_t  res;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;
  logic                  out_free;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]   mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: cfg_nxt.rows = cfg_data[ROWS_CFG_W-1:0];
        CFG_COLS: cfg_nxt.cols = cfg_data[COLS_CFG_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  // The controller only raises a result when the output register is free.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.data;
      out_stat_nxt  = res.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows  <= ROWS_CFG_W'(64);
      cfg_r.cols  <= COLS_CFG_W'(127);
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  mcmn_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .opcode       (in_tuser),
    .row_index    (in_tdata[5:0]),
    .col_index    (in_tdata[12:6]),
    .sample_value (in_tdata[28:13]),
    .out_free     (out_free),
    .cfg          (cfg_r),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

  mcmn_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mcmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ hw/rtl/mcmn_store.sv @@
// Sample matrix memory: one write port and one read port with registered data.
// Depends on mcmn_pkg for the sample width.
module mcmn_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [mcmn_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [mcmn_pkg::SAMPLE_W-1:0] rdata
);
  import mcmn_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mcmn_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, shared by the mean
// and the scaling steps. Depends on mcmn_pkg for widths and request types.
module mcmn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mcmn_pkg::div_req_t  req,
  output mcmn_pkg::div_rsp_t  rsp
);
  import mcmn_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ hw/rtl/mcmn_ctrl.sv @@
// Sequencer: element reads and writes, and the three passes of a column
// normalise over the store. Depends on mcmn_pkg; drives mcmn_store and mcmn_div.
module mcmn_ctrl #(
  parameter int MAX_ROWS = mcmn_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcmn_pkg::MAX_COLS_DEF,
  parameter int AW       = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcmn_pkg::OPC_W-1:0]    opcode,
  input  logic [mcmn_pkg::ROW_W-1:0]    row_index,
  input  logic [mcmn_pkg::COL_W-1:0]    col_index,
  input  logic [mcmn_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                          out_free,
  input  mcmn_pkg::cfg_t                cfg,
  output mcmn_pkg::result_t             res,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [mcmn_pkg::SAMPLE_W-1:0] mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [mcmn_pkg::SAMPLE_W-1:0] mem_rdata,
  output mcmn_pkg::div_req_t            div_req,
  input  mcmn_pkg::div_rsp_t            div_rsp
);
  import mcmn_pkg::*;

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int SUM_W = SAMPLE_W + RIW + 1;
  localparam int DEV_W = SAMPLE_W + 1;

  state_t state_r, state_nxt;
  logic [RIW-1:0]             row_r, row_nxt;
  logic [CIW-1:0]             col_r, col_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       sneg_r, sneg_nxt;
  logic signed [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic [DEV_W-1:0]           maxdev_r, maxdev_nxt;
  logic                       dneg_r, dneg_nxt;
  logic                       flat_r, flat_nxt;
  logic [SAMPLE_W-1:0]        qval_r, qval_nxt;

  logic [RCW-1:0]          rows_eff;
  logic [CCW-1:0]          cols_eff;
  logic                    accept, in_range, last_row, last_col;
  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]        dev_abs;
  logic signed [SUM_W-1:0] sum_full;
  logic [SUM_W-1:0]        sum_mag;
  logic [SAMPLE_W-1:0]     qlow;

  function automatic logic [AW-1:0] addr_of(input int r, input int c);
    return AW'(r * MAX_COLS + c);
  endfunction

  always_comb begin
    rows_eff = (32'(cfg.rows) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg.rows);
    cols_eff = (32'(cfg.cols) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg.cols);
  end

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_range = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
  assign last_row = (32'(row_r) == 32'(rows_eff) - 1);
  assign last_col = (32'(col_r) == 32'(cols_eff) - 1);
  assign dev      = $signed({mem_rdata[SAMPLE_W-1], mem_rdata})
                  - $signed({mean_r[SAMPLE_W-1], mean_r});
  assign dev_abs  = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign sum_full = sum_r + SUM_W'($signed(mem_rdata));
  assign sum_mag  = sum_full[SUM_W-1] ? SUM_W'(-sum_full) : SUM_W'(sum_full);
  assign qlow     = div_rsp.quo[SAMPLE_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_READ: if (in_range) state_nxt = S_RD_WAIT;
            OP_NORM: if (cfg.rows != '0 && cols_eff != '0) state_nxt = S_SUM_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:  state_nxt = S_IDLE;
      S_SUM_RD:   state_nxt = S_SUM_ACC;
      S_SUM_ACC:  state_nxt = last_row ? S_MEAN_DIV : S_SUM_RD;
      S_MEAN_DIV: if (div_rsp.done) state_nxt = S_MAX_RD;
      S_MAX_RD:   state_nxt = S_MAX_ACC;
      S_MAX_ACC:  state_nxt = last_row ? S_Q_RD : S_MAX_RD;
      S_Q_RD:     state_nxt = S_Q_LD;
      S_Q_LD:     state_nxt = (maxdev_r == '0) ? S_Q_WR : S_Q_DIV;
      S_Q_DIV:    if (div_rsp.done) state_nxt = S_Q_WR;
      S_Q_WR: begin
        if (!last_row) begin
          state_nxt = S_Q_RD;
        end else begin
          state_nxt = last_col ? S_DONE : S_SUM_RD;
        end
      end
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory, divider and result outputs.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr_of(int'(row_r), int'(col_r));
    mem_wdata   = qval_r;
    mem_re      = 1'b0;
    mem_raddr   = addr_of(int'(row_r), int'(col_r));
    div_req     = '0;
    res         = '0;
    case (state_r)
      S_IDLE: begin
        mem_waddr = addr_of(int'(row_index), int'(col_index));
        mem_wdata = sample_value;
        mem_raddr = addr_of(int'(row_index), int'(col_index));
        if (accept) begin
          case (opcode)
            OP_WRITE: begin
              mem_we     = in_range;
              res.valid  = 1'b1;
              res.status = in_range ? ST_OK : ST_RANGE;
            end
            OP_READ: begin
              mem_re = in_range;
              if (!in_range) begin
                res.valid  = 1'b1;
                res.status = ST_RANGE;
              end
            end
            OP_NORM: begin
              if (cfg.rows == '0) begin
                res.valid  = 1'b1;
                res.status = ST_RANGE;
              end else if (cols_eff == '0) begin
                res.valid  = 1'b1;
                res.status = ST_OK;
              end
            end
            default: begin
              res.valid  = 1'b1;
              res.status = ST_RANGE;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        res.valid  = 1'b1;
        res.data   = $signed(mem_rdata);
        res.status = ST_OK;
      end
      S_SUM_RD, S_MAX_RD, S_Q_RD: mem_re = 1'b1;
      S_SUM_ACC: begin
        if (last_row) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(sum_mag);
          div_req.den   = DIV_DW'(rows_eff);
        end
      end
      S_Q_LD: begin
        if (maxdev_r != '0) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'({dev_abs, 15'b0});
          div_req.den   = DIV_DW'(maxdev_r);
        end
      end
      S_Q_WR: mem_we = 1'b1;
      S_DONE: begin
        res.valid  = 1'b1;
        res.status = flat_r ? ST_FLAT : ST_OK;
      end
      default: ;
    endcase
  end

  // Datapath registers. The last sample is added in S_SUM_ACC on its way into
  // the divider, so the mean divide starts from the complete column sum.
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    sum_nxt    = sum_r;
    sneg_nxt   = sneg_r;
    mean_nxt   = mean_r;
    maxdev_nxt = maxdev_r;
    dneg_nxt   = dneg_r;
    flat_nxt   = flat_r;
    qval_nxt   = qval_r;
    case (state_r)
      S_IDLE: begin
        row_nxt  = '0;
        col_nxt  = '0;
        sum_nxt  = '0;
        flat_nxt = 1'b0;
      end
      S_SUM_ACC: begin
        sum_nxt = sum_full;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end
      S_MEAN_DIV: begin
        if (div_rsp.done) begin
          mean_nxt   = sneg_r ? -$signed(qlow) : $signed(qlow);
          maxdev_nxt = '0;
        end
      end
      S_MAX_ACC: begin
        if (dev_abs > maxdev_r) maxdev_nxt = dev_abs;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end
      S_Q_LD: begin
        dneg_nxt = dev[DEV_W-1];
        qval_nxt = '0;
        if (maxdev_r == '0) flat_nxt = 1'b1;
      end
      S_Q_DIV: begin
        if (div_rsp.done) begin
          if (dneg_r) begin
            qval_nxt = -qlow;
          end else if (div_rsp.quo > DIV_NW'(32767)) begin
            qval_nxt = SAMPLE_W'(32767);
          end else begin
            qval_nxt = qlow;
          end
        end
      end
      S_Q_WR: begin
        if (!last_row) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt = '0;
          col_nxt = col_r + 1'b1;
          sum_nxt = '0;
        end
      end
      default: ;
    endcase
    if (state_r == S_SUM_ACC && last_row) begin
      sneg_nxt = sum_full[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    sum_r    <= sum_nxt;
    sneg_r   <= sneg_nxt;
    mean_r   <= mean_nxt;
    maxdev_r <= maxdev_nxt;
    dneg_r   <= dneg_nxt;
    flat_r   <= flat_nxt;
    qval_r   <= qval_nxt;
  end

endmodule

@@ dv/column_mean_maxabs_normalizer_tb.sv @@
// Self-checking testbench for column_mean_maxabs_normalizer: a stream driver, a result
// monitor and a predictor of the matrix store and its column normalisation.
// Depends on mcmn_pkg and the block's RTL only.
`timescale 1ns / 100ps

module column_mean_maxabs_normalizer_tb;
  import mcmn_pkg::*;

  localparam int NROWS = 64;
  localparam int NCOLS = 128;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic [OPC_W-1:0]         op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample;
  } txn_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] data;
    logic [STAT_W-1:0]          status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OPC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  column_mean_maxabs_normalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  txn_t    pending[$];
  answer_t expected_answers[$];
  txn_t    driven;
  longint  cycle_count = 0;
  int      fail_count = 0;
  int      n_items = 0;

  // Predictor state.
  logic signed [SAMPLE_W-1:0] shadow_store [NROWS][NCOLS];
  int pred_rows = 64;
  int pred_cols = 127;

  // Generator bookkeeping: which entries are defined, and the settings in force.
  bit written [NROWS][NCOLS];
  int gen_rows = 64;
  int gen_cols = 127;

  function automatic bit stall_now();
    if ((cycle_count % 200000) < 40000) return 1'b0;
    return $urandom_range(99) < 17;
  endfunction

  function automatic bit normalize_column(int c, int rows);
    longint sum, mean, dev, maxdev, q;
    sum = 0;
    maxdev = 0;
    for (int r = 0; r < rows; r++) sum += shadow_store[r][c];
    mean = sum / rows;
    for (int r = 0; r < rows; r++) begin
      dev = shadow_store[r][c] - mean;
      if (dev < 0) dev = -dev;
      if (dev > maxdev) maxdev = dev;
    end
    for (int r = 0; r < rows; r++) begin
      q = 0;
      if (maxdev != 0) begin
        q = ((shadow_store[r][c] - mean) * 32768) / maxdev;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      shadow_store[r][c] = q[15:0];
    end
    return maxdev == 0;
  endfunction

  function automatic answer_t predict_answer(txn_t t);
    answer_t a;
    int rows, cols;
    bit flat;
    a.data = '0;
    a.status = ST_OK;
    case (t.op)
      OP_WRITE: shadow_store[t.row][t.col] = t.sample;
      OP_READ:  a.data = shadow_store[t.row][t.col];
      OP_NORM: begin
        rows = pred_rows;
        cols = pred_cols;
        if (rows == 0) begin
          a.status = ST_RANGE;
        end else begin
          flat = 1'b0;
          if (rows > NROWS) rows = NROWS;
          if (cols > NCOLS) cols = NCOLS;
          for (int c = 0; c < cols; c++)
            if (normalize_column(c, rows)) flat = 1'b1;
          if (flat) a.status = ST_FLAT;
        end
      end
      default: a.status = ST_RANGE;
    endcase
    return a;
  endfunction

  // Driver: input stream and register writes, never both at once.
  always @(posedge clk) begin
    bit in_free, cfg_free, go_in, go_cfg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_answers.insert(expected_answers.size(), predict_answer(driven));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) pred_rows = cfg_data & 8'h7f;
        else pred_cols = cfg_data;
      end
      in_free = !in_tvalid || in_tready;
      cfg_free = !cfg_valid || cfg_ready;
      if (in_free && cfg_free) begin
        go_in = 1'b0;
        go_cfg = 1'b0;
        if (pending.size() > 0 && !stall_now()) begin
          if (pending[0].is_cfg) begin
            // Registers change only once every answer is back.
            if (expected_answers.size() == 0) begin
              driven = pending.pop_front();
              go_cfg = 1'b1;
            end
          end else begin
            driven = pending.pop_front();
            go_in = 1'b1;
          end
        end
        in_tvalid <= go_in;
        cfg_valid <= go_cfg;
        if (go_in) begin
          in_tdata <= {3'b000, driven.sample, driven.col, driven.row};
          in_tuser <= driven.op;
        end
        if (go_cfg) begin
          cfg_index <= driven.reg_idx;
          cfg_data <= driven.reg_val;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result: data_out %0d status %0d", $signed(out_tdata), out_tuser);
          fail_count++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_tdata !== exp_a.data) begin
            $error("data_out: expected %0d, actual %0d", exp_a.data, $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser !== exp_a.status) begin
            $error("status: expected %0d, actual %0d", exp_a.status, out_tuser);
            fail_count++;
          end
        end
      end
      out_tready <= !stall_now();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("column_mean_maxabs_normalizer_tb NOT OK");
      $finish;
    end
  end

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    txn_t t;
    t = '{default: '0};
    t.is_cfg = 1'b1;
    t.reg_idx = idx;
    t.reg_val = val[7:0];
    pending.insert(pending.size(), t);
    if (idx == CFG_ROWS) gen_rows = val & 8'h7f;
    else gen_cols = val & 8'hff;
  endtask

  task automatic push_op(logic [OPC_W-1:0] op, int r, int c, int v);
    txn_t t;
    t = '{default: '0};
    t.op = op;
    t.row = r[5:0];
    t.col = c[6:0];
    t.sample = v[15:0];
    pending.insert(pending.size(), t);
    n_items++;
  endtask

  task automatic push_write(int r, int c, int v);
    push_op(OP_WRITE, r, c, v);
    written[r][c] = 1'b1;
  endtask

  task automatic push_read(int r, int c);
    if (written[r][c]) push_op(OP_READ, r, c, $urandom);
  endtask

  // Any entry inside the region still undefined is written first.
  task automatic push_normalize();
    int rows, cols;
    rows = (gen_rows > NROWS) ? NROWS : gen_rows;
    cols = (gen_cols > NCOLS) ? NCOLS : gen_cols;
    for (int c = 0; c < cols; c++)
      for (int r = 0; r < rows; r++)
        if (!written[r][c]) push_write(r, c, $urandom);
    push_op(OP_NORM, $urandom, $urandom, $urandom);
  endtask

  task automatic fill_column(int c, int rows);
    int mode, base;
    mode = $urandom_range(9);
    base = $urandom;
    for (int r = 0; r < rows; r++) begin
      if (mode == 0) push_write(r, c, base);
      else if (mode < 4) push_write(r, c, (base & 16'hfff0) + $urandom_range(15));
      else push_write(r, c, $urandom);
    end
  endtask

  initial begin
    int rows, cols, extra, pick, r, c;

    // Directed part.
    push_cfg(CFG_ROWS, 2);
    push_cfg(CFG_COLS, 1);
    push_write(0, 0, 32767);
    push_write(1, 0, -32768);
    push_write(63, 127, -1);
    push_read(63, 127);
    push_read(0, 0);
    push_op(OP_RSVD, 63, 127, -1);
    push_normalize();
    push_read(0, 0);
    push_read(1, 0);
    push_cfg(CFG_ROWS, 0);
    push_normalize();
    push_cfg(CFG_ROWS, 1);
    push_cfg(CFG_COLS, 0);
    push_normalize();
    // A constant column gives zero spread.
    push_cfg(CFG_ROWS, 3);
    push_cfg(CFG_COLS, 2);
    for (int i = 0; i < 3; i++) push_write(i, 1, 1234);
    push_normalize();
    push_read(2, 1);
    push_cfg(CFG_ROWS, 64);
    push_normalize();
    push_read(63, 1);
    push_cfg(CFG_ROWS, 1);
    push_cfg(CFG_COLS, 128);
    push_normalize();
    push_cfg(CFG_ROWS, 127);
    push_cfg(CFG_COLS, 1);
    push_normalize();
    push_cfg(CFG_ROWS, 1);
    push_cfg(CFG_COLS, 255);
    push_normalize();
    push_read(0, 127);

    // Random phases: configure, fill the region, mix in traffic, normalise, read back.
    while (n_items < 1450) begin
      pick = $urandom_range(99);
      if (pick < 80) rows = $urandom_range(8, 1);
      else if (pick < 92) rows = $urandom_range(64, 9);
      else if (pick < 96) rows = 0;
      else rows = $urandom_range(127, 65);
      pick = $urandom_range(99);
      if (pick < 85) cols = $urandom_range(4);
      else cols = $urandom_range(16, 5);
      if (cols > 4 && rows > 2) rows = $urandom_range(2, 1);
      push_cfg(CFG_ROWS, rows);
      push_cfg(CFG_COLS, cols);
      if (rows > 0)
        for (c = 0; c < cols; c++) fill_column(c, (rows > NROWS) ? NROWS : rows);
      extra = $urandom_range(12);
      for (int i = 0; i < extra; i++) begin
        pick = $urandom_range(9);
        r = $urandom_range(NROWS - 1);
        c = $urandom_range(NCOLS - 1);
        if (pick < 4) push_write(r, c, $urandom);
        else if (pick < 8) push_read(r, c);
        else if (pick == 8) push_op(OP_RSVD, r, c, $urandom);
        else push_read($urandom_range(3), $urandom_range(cols));
      end
      push_normalize();
      if ($urandom_range(3) == 0) push_normalize();
      for (int i = 0; i < 4; i++)
        push_read($urandom_range((rows >= NROWS) ? NROWS - 1 : rows), $urandom_range(cols));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending.size() == 0 && !in_tvalid && !cfg_valid && expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("column_mean_maxabs_normalizer_tb OK");
    end else begin
      $display("column_mean_maxabs_normalizer_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mcmn_pkg.sv
hw/rtl/mcmn_store.sv
hw/rtl/mcmn_div.sv
hw/rtl/mcmn_ctrl.sv
hw/rtl/column_mean_maxabs_normalizer.sv
dv/column_mean_maxabs_normalizer_tb.sv
